// ===== src/qse_pkg.sv =====
// qse_pkg: shared constants, state encoding and control struct for the sort engine
// depends on nothing; used by every module of the block
package qse_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int DATA_W    = 32;
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

	typedef enum logic {
		ST_LOAD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic ins;
		logic shift;
		logic emit_last;
		logic trunc;
	} ctrl_t;

endpackage

// ===== src/qse_cell.sv =====
// qse_cell: one slot of the sorted row, keeps its value in ascending order
// depends on qse_pkg for widths and the control struct
module qse_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  qse_pkg::ctrl_t                      ctrl,
	input  logic signed [qse_pkg::DATA_W-1:0]   new_value,
	input  logic signed [qse_pkg::DATA_W-1:0]   prev_value,
	input  logic                                prev_valid,
	input  logic                                prev_gt,
	input  logic signed [qse_pkg::DATA_W-1:0]   next_value,
	input  logic                                next_valid,
	output logic signed [qse_pkg::DATA_W-1:0]   cell_value,
	output logic                                cell_valid,
	output logic                                gt
);

	logic signed [qse_pkg::DATA_W-1:0] value_q;
	logic                              valid_q;

	// empty slot acts as plus infinity
	assign gt         = !valid_q || (value_q > new_value);
	assign cell_value = value_q;
	assign cell_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= next_valid;
		end else if (ctrl.ins && gt) begin
			valid_q <= prev_gt ? prev_valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			value_q <= next_value;
		end else if (ctrl.ins && gt) begin
			value_q <= prev_gt ? prev_value : new_value;
		end
	end

endmodule

// ===== src/qse_ctrl.sv =====
// qse_ctrl: load and emit sequencer, item count and overflow tracking
// depends on qse_pkg for the state type, widths and control struct
module qse_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           last,
	output logic           busy,
	output qse_pkg::ctrl_t ctrl
);

	qse_pkg::state_t           state_q, state_nxt;
	logic [qse_pkg::CNT_W-1:0] count_q;
	logic                      ovf_q;
	logic                      accept;
	logic                      full;

	assign full   = (count_q == qse_pkg::CNT_W'(qse_pkg::MAX_ITEMS));
	assign accept = start && (state_q == qse_pkg::ST_LOAD);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			qse_pkg::ST_LOAD: begin
				if (accept && last) state_nxt = qse_pkg::ST_EMIT;
			end
			qse_pkg::ST_EMIT: begin
				if (count_q == qse_pkg::CNT_W'(1)) state_nxt = qse_pkg::ST_LOAD;
			end
			default: state_nxt = qse_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		busy           = 1'b0;
		ctrl.ins       = 1'b0;
		ctrl.shift     = 1'b0;
		ctrl.emit_last = 1'b0;
		ctrl.trunc     = ovf_q;
		case (state_q)
			qse_pkg::ST_LOAD: begin
				ctrl.ins = accept && !full;
			end
			qse_pkg::ST_EMIT: begin
				busy           = 1'b1;
				ctrl.shift     = 1'b1;
				ctrl.emit_last = (count_q == qse_pkg::CNT_W'(1));
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qse_pkg::ST_LOAD;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				qse_pkg::ST_LOAD: begin
					if (accept) begin
						if (full) ovf_q <= 1'b1;
						else      count_q <= count_q + qse_pkg::CNT_W'(1);
					end
				end
				qse_pkg::ST_EMIT: begin
					count_q <= count_q - qse_pkg::CNT_W'(1);
					if (count_q == qse_pkg::CNT_W'(1)) ovf_q <= 1'b0;
				end
				default: begin
					count_q <= '0;
				end
			endcase
		end
	end

endmodule

// ===== src/quicksort_engine_top.sv =====
// quicksort_engine_top: collects a set of signed values and returns them in ascending order
// depends on qse_pkg, qse_ctrl and a row of qse_cell slots
//
// usage: drive value and last with start high; an item is taken at a clock edge
// where start is high and busy is low. each item is inserted into its ordered
// place in a row of MAX_ITEMS cells in the cycle it is taken. items beyond the
// row's capacity are dropped and the set is flagged truncated. the item marked
// last closes the set: busy rises the next cycle and the row shifts toward
// cell 0 once per cycle, giving one result per cycle on sorted_value with
// strobe high for exactly one cycle, last_out on the largest value. the
// state register turns to emit when the last item is taken, and each result
// is then registered from cell 0 into the output registers. results cannot
// be held off by the receiver.
// busy falls as the final result shows, and a new set may start right then.
// reset empties the row and clears the count and overflow flag.
module quicksort_engine_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [qse_pkg::DATA_W-1:0] value,
	input  logic                              last,
	output logic                              strobe,
	output logic signed [qse_pkg::DATA_W-1:0] sorted_value,
	output logic                              last_out,
	output logic                              truncated
);

	qse_pkg::ctrl_t                    ctrl;
	logic signed [qse_pkg::DATA_W-1:0] cell_value [qse_pkg::MAX_ITEMS];
	logic                              cell_valid [qse_pkg::MAX_ITEMS];
	logic                              cell_gt    [qse_pkg::MAX_ITEMS];

	logic                              strobe_q;
	logic signed [qse_pkg::DATA_W-1:0] sorted_value_q;
	logic                              last_out_q;
	logic                              truncated_q;

	qse_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.last   (last),
		.busy   (busy),
		.ctrl   (ctrl)
	);

	for (genvar i = 0; i < qse_pkg::MAX_ITEMS; i++) begin : g_cell
		logic signed [qse_pkg::DATA_W-1:0] prev_value, next_value;
		logic                              prev_valid, prev_gt, next_valid;

		if (i == 0) begin : g_head
			assign prev_value = '0;
			assign prev_valid = 1'b0;
			assign prev_gt    = 1'b0;
		end else begin : g_body
			assign prev_value = cell_value[i-1];
			assign prev_valid = cell_valid[i-1];
			assign prev_gt    = cell_gt[i-1];
		end

		if (i == qse_pkg::MAX_ITEMS - 1) begin : g_tail
			assign next_value = '0;
			assign next_valid = 1'b0;
		end else begin : g_link
			assign next_value = cell_value[i+1];
			assign next_valid = cell_valid[i+1];
		end

		qse_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.new_value  (value),
			.prev_value (prev_value),
			.prev_valid (prev_valid),
			.prev_gt    (prev_gt),
			.next_value (next_value),
			.next_valid (next_valid),
			.cell_value (cell_value[i]),
			.cell_valid (cell_valid[i]),
			.gt         (cell_gt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= ctrl.shift;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			sorted_value_q <= cell_value[0];
			last_out_q     <= ctrl.emit_last;
			truncated_q    <= ctrl.trunc;
		end
	end

	assign strobe       = strobe_q;
	assign sorted_value = sorted_value_q;
	assign last_out     = last_out_q;
	assign truncated    = truncated_q;

endmodule

// ===== src/qse_checker.sv =====
// qse_checker: port-level checks of the sort engine's emit sequence
// depends on qse_pkg; bound to quicksort_engine_top
module qse_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              last,
	input logic                              strobe,
	input logic signed [qse_pkg::DATA_W-1:0] sorted_value,
	input logic                              last_out,
	input logic                              truncated
);

	a_last_starts_emit: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && last |=> busy)
		else $error("last item did not start emission");

	a_busy_emits: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> strobe)
		else $error("emit cycle without result");

	a_run_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_out |-> !busy)
		else $error("still busy after final result");

	a_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && $past(strobe) && !$past(last_out)
			|-> sorted_value >= $past(sorted_value))
		else $error("results out of order");

	a_trunc_steady: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && $past(strobe) && !$past(last_out) |-> truncated == $past(truncated))
		else $error("truncated flag changed within a run");

endmodule

bind quicksort_engine_top qse_checker u_qse_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.last         (last),
	.strobe       (strobe),
	.sorted_value (sorted_value),
	.last_out     (last_out),
	.truncated    (truncated)
);

// ===== bench/tb_quicksort_engine_top.sv =====
// tb_quicksort_engine_top: self-checking bench for the sort engine, directed sets, capacity sets, random sets
// predicts each set's ascending output by ordered insertion and checks every result in order
// depends on qse_pkg and quicksort_engine_top
module tb_quicksort_engine_top;

	localparam int IDLE_LIMIT   = 500;
	localparam int RANDOM_ITEMS = 70;
	localparam int DRAIN_CYCLES = qse_pkg::MAX_ITEMS + 8;

	typedef logic signed [qse_pkg::DATA_W-1:0] elem_t;

	typedef struct packed {
		elem_t value;
		logic  last_out;
		logic  truncated;
	} sorted_entry_t;

	typedef enum {FILL_WIDE, FILL_DUPS, FILL_RISING, FILL_FALLING} fill_t;

	localparam elem_t VAL_MIN = elem_t'(32'h8000_0000);
	localparam elem_t VAL_MAX = elem_t'(32'h7fff_ffff);

	logic  clk    = 1'b0;
	logic  arst_n = 1'b0;
	logic  start  = 1'b0;
	elem_t value  = '0;
	logic  last   = 1'b0;
	logic  busy;
	logic  strobe;
	elem_t sorted_value;
	logic  last_out;
	logic  truncated;

	elem_t         ordered_set [qse_pkg::MAX_ITEMS];
	int            set_len      = 0;
	logic          set_overflow = 1'b0;
	sorted_entry_t expected_sorted[$];
	elem_t         outgoing_set[$];
	int            burst_left   = 0;
	int            idle_cycles  = 0;
	int            errors       = 0;
	int            items_sent   = 0;

	quicksort_engine_top i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.value       (value),
		.last        (last),
		.strobe      (strobe),
		.sorted_value(sorted_value),
		.last_out    (last_out),
		.truncated   (truncated)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// keeps the open set in ascending order as items arrive
	task automatic take_element(input elem_t v, input logic is_last);
		int j;
		int k;
		if (set_len < qse_pkg::MAX_ITEMS) begin
			j = set_len;
			while (j > 0 && ordered_set[j-1] > v) begin
				ordered_set[j] = ordered_set[j-1];
				j--;
			end
			ordered_set[j] = v;
			set_len++;
		end else begin
			set_overflow = 1'b1;
		end
		if (is_last) begin
			for (k = 0; k < set_len; k++)
				expected_sorted.push_back('{value: ordered_set[k],
					last_out: (k == set_len - 1), truncated: set_overflow});
			set_len      = 0;
			set_overflow = 1'b0;
		end
	endtask

	task automatic check_result();
		sorted_entry_t exp_entry;
		if (expected_sorted.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual %0d", $time, sorted_value);
			errors++;
		end else begin
			exp_entry = expected_sorted.pop_front();
			if (sorted_value !== exp_entry.value) begin
				$display("%0t: sorted_value expected %0d actual %0d", $time,
					$signed(exp_entry.value), sorted_value);
				errors++;
			end
			if (last_out !== exp_entry.last_out) begin
				$display("%0t: last_out expected %0b actual %0b", $time,
					exp_entry.last_out, last_out);
				errors++;
			end
			if (truncated !== exp_entry.truncated) begin
				$display("%0t: truncated expected %0b actual %0b", $time,
					exp_entry.truncated, truncated);
				errors++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (strobe)
				check_result();
			if (start && !busy)
				take_element(value, last);
			if (strobe || (start && !busy)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= IDLE_LIMIT) begin
					$display("quicksort_engine_top test failed");
					$finish;
				end
			end
		end
	end

	task automatic send_item(input elem_t v, input logic is_last);
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
		start <= 1'b1;
		value <= v;
		last  <= is_last;
		do @(posedge clk); while (busy);
		burst_left--;
		items_sent++;
	endtask

	task automatic send_set();
		elem_t v;
		while (outgoing_set.size() > 0) begin
			v = outgoing_set.pop_front();
			send_item(v, outgoing_set.size() == 0);
		end
	endtask

	task automatic fill_set(input int n, input fill_t style);
		elem_t base;
		int k;
		base = elem_t'($urandom);
		outgoing_set.delete();
		for (k = 0; k < n; k++) begin
			case (style)
				FILL_WIDE:    outgoing_set.push_back(elem_t'($urandom));
				FILL_DUPS:    outgoing_set.push_back(elem_t'(int'($urandom_range(0, 4)) - 2));
				FILL_RISING:  outgoing_set.push_back(base + elem_t'(k));
				FILL_FALLING: outgoing_set.push_back(base - elem_t'(k));
				default:      outgoing_set.push_back(elem_t'($urandom));
			endcase
		end
	endtask

	task automatic wait_for_results();
		start      <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (expected_sorted.size() > 0)
			@(posedge clk);
	endtask

	task automatic test_single_items();
		outgoing_set = '{VAL_MIN};
		send_set();
		outgoing_set = '{VAL_MAX};
		send_set();
		outgoing_set = '{elem_t'(0)};
		send_set();
		outgoing_set = '{elem_t'(-1)};
		send_set();
	endtask

	task automatic test_small_sets();
		outgoing_set = '{VAL_MAX, VAL_MIN, elem_t'(0), elem_t'(-1), elem_t'(1)};
		send_set();
		outgoing_set = '{elem_t'(7), elem_t'(7), elem_t'(7)};
		send_set();
		outgoing_set = '{elem_t'(3), elem_t'(2), elem_t'(1), elem_t'(0)};
		send_set();
		outgoing_set = '{elem_t'(32'h5555_5555), elem_t'(32'haaaa_aaaa)};
		send_set();
		wait_for_results();
	endtask

	// exactly full, then overflow with the last item dropped
	task automatic test_capacity();
		fill_set(qse_pkg::MAX_ITEMS, FILL_FALLING);
		send_set();
		fill_set(qse_pkg::MAX_ITEMS + 1, FILL_WIDE);
		send_set();
	endtask

	task automatic test_random_sets();
		int   target;
		int   n;
		logic paused;
		fill_t style;
		target = items_sent + RANDOM_ITEMS;
		paused = 1'b0;
		while (items_sent < target) begin
			n = $urandom_range(1, 10);
			style = fill_t'($urandom_range(0, 3));
			fill_set(n, style);
			send_set();
			if (!paused && items_sent > target - RANDOM_ITEMS / 2) begin
				wait_for_results();
				paused = 1'b1;
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_items();
		test_small_sets();
		test_capacity();
		test_random_sets();
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("quicksort_engine_top test passed");
		else
			$display("quicksort_engine_top test failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/qse_pkg.sv
src/qse_cell.sv
src/qse_ctrl.sv
src/quicksort_engine_top.sv
src/qse_checker.sv
bench/tb_quicksort_engine_top.sv
